@@ src/tspq_pkg.sv @@
// package for the three-level strict priority queue: constants, codes and link types
`timescale 1ns / 1ps

package tspq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int LEVELS    = 3;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPRI = 2'd3;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] LVL_LO  = 2'd0;
    localparam logic [1:0] LVL_MID = 2'd1;
    localparam logic [1:0] LVL_HI  = 2'd2;

    localparam logic [1:0] PRI_NONE = 2'd0;

    typedef struct packed {
        logic apply;
        logic capture;
    } tspq_cmd_t;

    typedef struct packed {
        logic need_read;
    } tspq_sts_t;

endpackage

@@ src/tspq_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps

module tspq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tspq_ctrl.sv @@
// controller state machine for the priority queue
`timescale 1ns / 1ps

module tspq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  tspq_pkg::tspq_sts_t sts,
    output tspq_pkg::tspq_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        cmd.apply   = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = sts.need_read ? S_READ : S_RESP;
                end
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/tspq_dp.sv @@
// datapath: level pointers and counts, entry store and result registers
`timescale 1ns / 1ps

module tspq_dp #(
    parameter int DEPTH = tspq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tspq_pkg::tspq_cmd_t               cmd,
    output tspq_pkg::tspq_sts_t               sts,
    input  logic                              kind,
    input  logic signed [tspq_pkg::DATA_W-1:0] value,
    input  logic [1:0]                        priority_req,
    output logic signed [tspq_pkg::DATA_W-1:0] data_out,
    output logic [1:0]                        status,
    output logic [tspq_pkg::OCC_W-1:0]        occupancy,
    output logic                              is_empty,
    output logic                              is_full
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MEM_D  = tspq_pkg::LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    logic [PTR_W-1:0] head_reg  [tspq_pkg::LEVELS];
    logic [PTR_W-1:0] tail_reg  [tspq_pkg::LEVELS];
    logic [CNT_W-1:0] count_reg [tspq_pkg::LEVELS];
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;

    logic signed [tspq_pkg::DATA_W-1:0] data_out_reg;
    logic [1:0]                         status_reg;
    logic [tspq_pkg::OCC_W-1:0]         occupancy_reg;
    logic                               is_empty_reg;
    logic                               is_full_reg;

    logic [1:0]             deq_lv;
    logic [1:0]             lv;
    logic [PTR_W-1:0]       head_sel;
    logic [PTR_W-1:0]       tail_sel;
    logic [PTR_W-1:0]       ptr_sel;
    logic [PTR_W-1:0]       ptr_adv;
    logic [1:0]             status_now;
    logic                   is_full_now;
    logic                   is_empty_now;
    logic                   ok_enq;
    logic                   ok_deq;
    logic [ADDR_W-1:0]      ram_addr;
    logic [tspq_pkg::DATA_W-1:0] ram_rdata;

    assign is_full_now  = (total_reg >= CNT_W'(DEPTH));
    assign is_empty_now = (total_reg == '0);

    always_comb
    begin
        if (count_reg[tspq_pkg::LVL_HI] != '0)
        begin
            deq_lv = tspq_pkg::LVL_HI;
        end
        else if (count_reg[tspq_pkg::LVL_MID] != '0)
        begin
            deq_lv = tspq_pkg::LVL_MID;
        end
        else
        begin
            deq_lv = tspq_pkg::LVL_LO;
        end
    end

    assign lv = (kind == tspq_pkg::KIND_DEQ) ? deq_lv : (priority_req - 2'd1);

    always_comb
    begin
        case (lv)
            tspq_pkg::LVL_LO:
            begin
                head_sel = head_reg[tspq_pkg::LVL_LO];
                tail_sel = tail_reg[tspq_pkg::LVL_LO];
            end
            tspq_pkg::LVL_MID:
            begin
                head_sel = head_reg[tspq_pkg::LVL_MID];
                tail_sel = tail_reg[tspq_pkg::LVL_MID];
            end
            tspq_pkg::LVL_HI:
            begin
                head_sel = head_reg[tspq_pkg::LVL_HI];
                tail_sel = tail_reg[tspq_pkg::LVL_HI];
            end
            default:
            begin
                head_sel = '0;
                tail_sel = '0;
            end
        endcase
    end

    assign ptr_sel = (kind == tspq_pkg::KIND_DEQ) ? head_sel : tail_sel;
    assign ptr_adv = (ptr_sel == PTR_W'(DEPTH - 1)) ? '0 : ptr_sel + PTR_W'(1);

    assign ok_enq = (kind == tspq_pkg::KIND_ENQ) && !is_full_now
                    && (priority_req != tspq_pkg::PRI_NONE);
    assign ok_deq = (kind == tspq_pkg::KIND_DEQ) && !is_empty_now;

    always_comb
    begin
        if (kind == tspq_pkg::KIND_DEQ)
        begin
            status_now = is_empty_now ? tspq_pkg::ST_EMPTY : tspq_pkg::ST_OK;
        end
        else if (is_full_now)
        begin
            status_now = tspq_pkg::ST_FULL;
        end
        else if (priority_req == tspq_pkg::PRI_NONE)
        begin
            status_now = tspq_pkg::ST_BADPRI;
        end
        else
        begin
            status_now = tspq_pkg::ST_OK;
        end
    end

    always_comb
    begin
        if (ok_enq)
        begin
            total_next = total_reg + CNT_W'(1);
        end
        else if (ok_deq)
        begin
            total_next = total_reg - CNT_W'(1);
        end
        else
        begin
            total_next = total_reg;
        end
    end

    assign ram_addr = ADDR_W'(lv) * ADDR_W'(DEPTH) + ADDR_W'(ptr_sel);

    // level bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tspq_pkg::LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (cmd.apply)
        begin
            for (int i = 0; i < tspq_pkg::LEVELS; i++)
            begin
                if (lv == 2'(i))
                begin
                    if (ok_enq)
                    begin
                        tail_reg[i]  <= ptr_adv;
                        count_reg[i] <= count_reg[i] + CNT_W'(1);
                    end
                    if (ok_deq)
                    begin
                        head_reg[i]  <= ptr_adv;
                        count_reg[i] <= count_reg[i] - CNT_W'(1);
                    end
                end
            end
            total_reg <= total_next;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            data_out_reg  <= '0;
            status_reg    <= status_now;
            occupancy_reg <= tspq_pkg::OCC_W'(total_next);
            is_empty_reg  <= (total_next == '0);
            is_full_reg   <= (total_next == CNT_W'(DEPTH));
        end
        else if (cmd.capture)
        begin
            data_out_reg <= ram_rdata;
        end
    end

    tspq_ram #(
        .WIDTH (tspq_pkg::DATA_W),
        .DEPTH (MEM_D)
    ) u_store (
        .clk   (clk),
        .we    (cmd.apply && ok_enq),
        .re    (cmd.apply && ok_deq),
        .addr  (ram_addr),
        .wdata (value),
        .rdata (ram_rdata)
    );

    assign sts.need_read = ok_deq;

    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

endmodule

@@ src/three_level_strict_priority_queue_top.sv @@
// Three-level strict priority queue: each request enqueues a word at priority 1..3 or
// dequeues the oldest word of the highest non-empty level, returning one result with
// a status and the new occupancy. One request is handled at a time: an enqueue or a
// failed request shows its result in the cycle after the request transfer, a successful
// dequeue passes through a read state first for the registered read port of the shared
// entry store (3*DEPTH words). The next request is taken in the cycle after the result
// transfer, so a new request waits until the last result has been taken.
`timescale 1ns / 1ps

module three_level_strict_priority_queue_top #(
    parameter int DEPTH = tspq_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic                               kind,
    input  logic signed [tspq_pkg::DATA_W-1:0] value,
    input  logic [1:0]                         priority_req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [tspq_pkg::DATA_W-1:0] data_out,
    output logic [1:0]                         status,
    output logic [tspq_pkg::OCC_W-1:0]         occupancy,
    output logic                               is_empty,
    output logic                               is_full
);

    tspq_pkg::tspq_cmd_t cmd;
    tspq_pkg::tspq_sts_t sts;

    tspq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tspq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .value        (value),
        .priority_req (priority_req),
        .data_out     (data_out),
        .status       (status),
        .occupancy    (occupancy),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule

@@ src/tspq_checker.sv @@
// port-level checks for the priority queue and their binding to the top level
`timescale 1ns / 1ps

module tspq_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic signed [tspq_pkg::DATA_W-1:0] data_out,
    input logic [1:0]                         status,
    input logic [tspq_pkg::OCC_W-1:0]         occupancy,
    input logic                               is_empty,
    input logic                               is_full
);

    // one request in flight: no new transfer while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid)
        else $error("request taken while result pending");

    // a failed request returns no data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != tspq_pkg::ST_OK) |-> (data_out == '0))
        else $error("data on failed request");

    // empty flag agrees with occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> (occupancy == '0) && !is_full)
        else $error("empty flag inconsistent");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(status))
        else $error("result changed while stalled");

endmodule

bind three_level_strict_priority_queue_top tspq_checker u_tspq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .is_full   (is_full)
);
